@@ rtl/core/scancode_to_ascii_fifo_defines.svh @@
// ---------------------------------------------------------------------------
// Scancode decoder assertion macros
// Shared concurrent assertion wrappers, reset-qualified on an active-low reset.
// ---------------------------------------------------------------------------
`ifndef SCANCODE_TO_ASCII_FIFO_DEFINES_SVH
`define SCANCODE_TO_ASCII_FIFO_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define SC2A_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SC2A_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/sc2a_pkg.sv @@
// ---------------------------------------------------------------------------
// sc2a_pkg
// Types, scancode constants and the set 1 character tables.
// ---------------------------------------------------------------------------
`default_nettype none

package sc2a_pkg;

  localparam int CHAR_W    = 7;
  localparam int CODE_W    = 8;
  localparam int TBL_IDX_W = 6;
  localparam int TBL_DEPTH = 64;

  localparam logic [CODE_W-1:0] LSHIFT_MAKE  = 8'h2a;
  localparam logic [CODE_W-1:0] LSHIFT_BREAK = 8'haa;
  localparam logic [CODE_W-1:0] RSHIFT_MAKE  = 8'h36;
  localparam logic [CODE_W-1:0] RSHIFT_BREAK = 8'hb6;
  localparam logic [CODE_W-1:0] BREAK_BIT    = 8'h80;

  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [CODE_W-1:0] scan_byte;
  } in_item_t;

  typedef struct packed {
    logic              has_char;
    logic [CHAR_W-1:0] character;
  } out_item_t;

  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] ch;
  } push_t;

  // Entries 58..63 are padding: codes there give no character.
  localparam logic [CHAR_W-1:0] LOWER_MAP [TBL_DEPTH] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2d, 7'h3d, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6f, 7'h70, 7'h5b, 7'h5d, 7'h0a, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6a, 7'h6b, 7'h6c, 7'h3b,
    7'h27, 7'h60, 7'h00, 7'h5c, 7'h7a, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6e, 7'h6d, 7'h2c, 7'h2e, 7'h2f, 7'h00, 7'h2a,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  localparam logic [CHAR_W-1:0] UPPER_MAP [TBL_DEPTH] = '{
    7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e,
    7'h26, 7'h2a, 7'h28, 7'h29, 7'h5f, 7'h2b, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4f, 7'h50, 7'h7b, 7'h7d, 7'h0a, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4a, 7'h4b, 7'h4c, 7'h3a,
    7'h22, 7'h7e, 7'h00, 7'h7c, 7'h5a, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4e, 7'h4d, 7'h3c, 7'h3e, 7'h3f, 7'h00, 7'h2a,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

endpackage

`default_nettype wire

@@ rtl/core/sc2a_in_if.sv @@
// ---------------------------------------------------------------------------
// sc2a_in_if
// Valid/ready channel carrying scancode and read requests.
// ---------------------------------------------------------------------------
`default_nettype none

interface sc2a_in_if;
  logic               valid;
  logic               ready;
  sc2a_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sc2a_out_if.sv @@
// ---------------------------------------------------------------------------
// sc2a_out_if
// Valid/ready channel carrying read results.
// ---------------------------------------------------------------------------
`default_nettype none

interface sc2a_out_if;
  logic                valid;
  logic                ready;
  sc2a_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/scancode_to_ascii_fifo.sv @@
// ---------------------------------------------------------------------------
// scancode_to_ascii_fifo
// Set 1 scancode decoder feeding a character buffer, read on request.
// ---------------------------------------------------------------------------
// Usage:
//   in_bus carries one beat per item: operation 0 delivers a scancode byte,
//   operation 1 asks for one character. Scancode beats give no result; each
//   read beat gives exactly one beat on out_bus (has_char 0 and character 0
//   when the buffer is empty).
//   Shift make and break codes track the shift state; other break codes are
//   ignored. Make codes map through the upper or lower case table and any
//   non-zero character goes into a FIFO_DEPTH entry buffer; when it is full
//   the character is dropped.
//   Throughput: one beat per cycle on in_bus while out_bus does not stall;
//   each beat makes at most one buffer RAM access (one write or one read).
//   A read result is registered first in the read stage, at the edge that
//   accepts its beat, and then in the output register, which loads when
//   out_bus is not stalled.
//   Reset clears shift state, pointers and fill count; the buffer RAM is not
//   cleared, and the block accepts beats from the first cycle after reset.
//   If out_bus stalls, one result waits in the output register and one in
//   the read stage; in_bus.ready then drops until out_bus takes a beat.
// ---------------------------------------------------------------------------
`default_nettype none

module scancode_to_ascii_fifo #(
  parameter int FIFO_DEPTH = 256
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  sc2a_in_if.sink     in_bus,
  sc2a_out_if.source  out_bus
);

  logic            in_ready;
  logic            in_accept;
  logic            scan_vld;
  logic            pop_req;
  sc2a_pkg::push_t push;

  assign in_accept = in_bus.valid && in_ready;
  assign scan_vld  = in_accept && (in_bus.data.operation == sc2a_pkg::OP_SCAN);
  assign pop_req   = in_accept && (in_bus.data.operation == sc2a_pkg::OP_READ);
  assign in_bus.ready = in_ready;

  sc2a_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .scan_vld  (scan_vld),
    .scan_byte (in_bus.data.scan_byte),
    .push      (push)
  );

  sc2a_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop_req   (pop_req),
    .in_ready  (in_ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .out_item  (out_bus.data)
  );

endmodule

`default_nettype wire

@@ rtl/core/sc2a_decode.sv @@
// ---------------------------------------------------------------------------
// sc2a_decode
// Shift tracking and set 1 make code to ASCII lookup.
// ---------------------------------------------------------------------------
`default_nettype none

module sc2a_decode (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          scan_vld,
  input  wire logic [sc2a_pkg::CODE_W-1:0]   scan_byte,
  output sc2a_pkg::push_t                    push
);

  logic                              shift_r;
  logic                              shift_nxt;
  logic [sc2a_pkg::TBL_IDX_W-1:0]    tbl_idx;
  logic [sc2a_pkg::CHAR_W-1:0]       tbl_char;
  logic                              in_table;

  assign tbl_idx  = scan_byte[sc2a_pkg::TBL_IDX_W-1:0];
  // Bits 7:6 clear covers all make codes the table can hold.
  assign in_table = (scan_byte[sc2a_pkg::CODE_W-1:sc2a_pkg::TBL_IDX_W] == '0);
  assign tbl_char = shift_r ? sc2a_pkg::UPPER_MAP[tbl_idx] : sc2a_pkg::LOWER_MAP[tbl_idx];

  always_comb begin
    shift_nxt  = shift_r;
    push.valid = 1'b0;
    push.ch    = tbl_char;
    if (scan_vld) begin
      if (scan_byte == sc2a_pkg::LSHIFT_MAKE || scan_byte == sc2a_pkg::RSHIFT_MAKE) begin
        shift_nxt = 1'b1;
      end else if (scan_byte == sc2a_pkg::LSHIFT_BREAK ||
                   scan_byte == sc2a_pkg::RSHIFT_BREAK) begin
        shift_nxt = 1'b0;
      end else if ((scan_byte & sc2a_pkg::BREAK_BIT) == '0 && in_table) begin
        push.valid = (tbl_char != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= 1'b0;
    end else begin
      shift_r <= shift_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sc2a_fifo.sv @@
// ---------------------------------------------------------------------------
// sc2a_fifo
// Character ring buffer in a synchronous RAM, with a read stage and an
// output register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "scancode_to_ascii_fifo_defines.svh"

module sc2a_fifo #(
  parameter int FIFO_DEPTH = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire sc2a_pkg::push_t      push,
  input  wire logic                 pop_req,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output sc2a_pkg::out_item_t       out_item
);

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(FIFO_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(FIFO_DEPTH);

  logic [sc2a_pkg::CHAR_W-1:0] char_mem [FIFO_DEPTH];
  logic [sc2a_pkg::CHAR_W-1:0] rd_data_r;

  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          s1_valid_r, s1_valid_nxt;
  logic          s1_has_r, s1_has_nxt;
  logic          out_valid_r, out_valid_nxt;
  sc2a_pkg::out_item_t out_item_r, out_item_nxt;

  logic do_push;
  logic do_pop;
  logic s1_move;

  // Characters arriving at a full buffer are dropped.
  assign do_push  = push.valid && (count_r != FULL_CNT);
  assign do_pop   = pop_req && (count_r != '0);
  assign s1_move  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_move;

  always_ff @(posedge clk) begin
    if (do_push) begin
      char_mem[wr_ptr_r] <= push.ch;
    end
    if (do_pop) begin
      rd_data_r <= char_mem[rd_ptr_r];
    end
  end

  always_comb begin
    wr_ptr_nxt    = wr_ptr_r;
    rd_ptr_nxt    = rd_ptr_r;
    count_nxt     = count_r;
    s1_valid_nxt  = s1_valid_r;
    s1_has_nxt    = s1_has_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;

    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + AW'(1);
      count_nxt  = count_r + CW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + AW'(1);
      count_nxt  = count_r - CW'(1);
    end

    if (s1_valid_r && s1_move) begin
      out_valid_nxt          = 1'b1;
      out_item_nxt.has_char  = s1_has_r;
      out_item_nxt.character = s1_has_r ? rd_data_r : '0;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (pop_req) begin
      s1_valid_nxt = 1'b1;
      s1_has_nxt   = do_pop;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      count_r     <= '0;
      s1_valid_r  <= 1'b0;
      s1_has_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      count_r     <= count_nxt;
      s1_valid_r  <= s1_valid_nxt;
      s1_has_r    <= s1_has_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `SC2A_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_r <= FULL_CNT, "fill count over depth")
  `SC2A_ASSERT_NEXT(a_pop_stage, clk, rst_n, do_pop, s1_valid_r && s1_has_r, "pop lost in read stage")
  `SC2A_ASSERT_NEXT(a_full_drop, clk, rst_n, push.valid && count_r == FULL_CNT, count_r == FULL_CNT && $stable(wr_ptr_r), "push accepted while full")
  `SC2A_ASSERT_SAME(a_stall_cause, clk, rst_n, !in_ready, s1_valid_r && out_valid_r && !out_ready, "input stalled without a full pipe")

endmodule

`default_nettype wire
